// ----- hw/rtl/psu_pkg.sv -----
`default_nettype none
package psu_pkg;

	localparam int NUM_STAGES = 11;
	localparam int IN_W       = 344;
	localparam int OUT_W      = 296;
	localparam int CFG_W      = 48;
	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [16:0] HALF_ONE = 17'd32768;

	typedef enum logic [2:0] {
		CFG_LIFE_RATE  = 3'd0,
		CFG_SCALE_RATE = 3'd1,
		CFG_SPIN_RATE  = 3'd2,
		CFG_FADE_RATE  = 3'd3,
		CFG_ACCEL_X    = 3'd4,
		CFG_ACCEL_Y    = 3'd5,
		CFG_COLOR_STOP = 3'd6,
		CFG_COLOR_END  = 3'd7
	} cfg_idx_t;

	// One record travels down the pipeline; the product slots are reused by stage.
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] rot;
		logic signed [31:0] spn;
		logic signed [31:0] scl;
		logic signed [31:0] opa;
		logic signed [31:0] life;
		logic signed [31:0] lim;
		logic [19:0]        dt;
		logic signed [36:0] p0;
		logic signed [36:0] p1;
		logic signed [36:0] p2;
		logic signed [36:0] p3;
		logic signed [36:0] p4;
		logic signed [36:0] p5;
		logic               dead;
		logic               div_ok;
		logic [31:0]        rem;
		logic [15:0]        quo;
		logic [23:0]        tint;
	} rec_t;

endpackage
`default_nettype wire

// ----- hw/rtl/particle_state_update.sv -----
// Particle state update, one particle record per request.
// Input stream: s_tvalid/s_tready/s_tdata carries one particle record and its
// time step. Output stream: m_tvalid/m_tready/m_tdata carries the updated
// record, m_tuser is the dead flag. The wr_en/wr_index/wr_data port writes the
// rate and color registers; write them only while no request is in flight.
// A new request is accepted every cycle while s_tready is high: the pipeline
// is 11 register stages (products, saturating adds, a second product/add pair
// for rotation and position, and a restoring divider for the life fraction
// that resolves two quotient bits per stage, then the color blend). Each stage
// has its own valid bit, and a stage advances when the one after it is empty
// or advancing, so a stalled receiver fills the bubbles first and then holds
// s_tready low; nothing is dropped.
// Reset clears all valid bits and loads the register defaults (life rate 1.0,
// everything else zero).
`default_nettype none
module particle_state_update (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// pos_x, pos_y, vel_x, vel_y, rotation, spin, scale, opacity, age,
	// age_limit, time_step, zero pad
	input  wire logic [psu_pkg::IN_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_rotation, new_spin,
	// new_scale, new_opacity, new_age, tint
	output logic [psu_pkg::OUT_W-1:0]        m_tdata,
	// dead
	output logic                             m_tuser,
	input  wire logic                        wr_en,
	input  wire logic [2:0]                  wr_index,
	input  wire logic [psu_pkg::CFG_W-1:0]   wr_data
);
	import psu_pkg::*;

	logic signed [31:0] life_rate_q, scale_rate_q, spin_rate_q, fade_rate_q;
	logic signed [31:0] accel_x_q, accel_y_q;
	logic [47:0]        color_stops_q;
	logic [23:0]        color_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_rate_q   <= 32'sd65536;
			scale_rate_q  <= '0;
			spin_rate_q   <= '0;
			fade_rate_q   <= '0;
			accel_x_q     <= '0;
			accel_y_q     <= '0;
			color_stops_q <= '0;
			color_end_q   <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_LIFE_RATE:  life_rate_q   <= wr_data[31:0];
				CFG_SCALE_RATE: scale_rate_q  <= wr_data[31:0];
				CFG_SPIN_RATE:  spin_rate_q   <= wr_data[31:0];
				CFG_FADE_RATE:  fade_rate_q   <= wr_data[31:0];
				CFG_ACCEL_X:    accel_x_q     <= wr_data[31:0];
				CFG_ACCEL_Y:    accel_y_q     <= wr_data[31:0];
				CFG_COLOR_STOP: color_stops_q <= wr_data[47:0];
				CFG_COLOR_END:  color_end_q   <= wr_data[23:0];
				default: ;
			endcase
		end
	end

	// Product of a Q16.16 value and the time step, floored back to a Q21.16 result.
	function automatic logic signed [36:0] mulq(input logic signed [31:0] a,
			input logic [19:0] dt);
		logic signed [52:0] p;
		p = a * $signed({1'b0, dt});
		return p[52:16];
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] b,
			input logic signed [36:0] p);
		logic signed [37:0] s;
		s = 38'(b) + 38'(p);
		if (s > 38'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -38'sd2147483648)
			return 32'sh80000000;
		else
			return s[31:0];
	endfunction

	// Two steps of restoring division of rem by lim.
	function automatic rec_t div2(input rec_t r);
		rec_t o;
		logic [32:0] t;
		o = r;
		for (int i = 0; i < 2; i++) begin
			t = {o.rem, 1'b0};
			if (t >= {1'b0, o.lim}) begin
				o.rem = 32'(t - {1'b0, o.lim});
				o.quo = {o.quo[14:0], 1'b1};
			end else begin
				o.rem = t[31:0];
				o.quo = {o.quo[14:0], 1'b0};
			end
		end
		return o;
	endfunction

	function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
			input logic [16:0] t);
		logic [25:0] s;
		s = 26'(a * (ONE_Q16 - t)) + 26'(b * t) + 26'(HALF_ONE);
		return s[23:16];
	endfunction

	function automatic rec_t unpack_in(input logic [IN_W-1:0] d);
		rec_t r;
		r        = '0;
		r.px     = d[31:0];
		r.py     = d[63:32];
		r.vx     = d[95:64];
		r.vy     = d[127:96];
		r.rot    = d[159:128];
		r.spn    = d[191:160];
		r.scl    = d[223:192];
		r.opa    = d[255:224];
		r.life   = d[287:256];
		r.lim    = d[319:288];
		r.dt     = d[339:320];
		return r;
	endfunction

	function automatic rec_t stage_fn(input int k, input rec_t r);
		rec_t o;
		logic [16:0] f, t;
		logic [23:0] ca, cb;
		o = r;
		f = '0;
		t = '0;
		ca = '0;
		cb = '0;
		if (k == 1) begin
			o.p0 = mulq(life_rate_q, r.dt);
			o.p1 = mulq(scale_rate_q, r.dt);
			o.p2 = mulq(spin_rate_q, r.dt);
			o.p3 = mulq(fade_rate_q, r.dt);
			o.p4 = mulq(accel_x_q, r.dt);
			o.p5 = mulq(accel_y_q, r.dt);
		end else if (k == 2) begin
			o.life = add_sat(r.life, r.p0);
			o.dead = (o.life >= r.lim);
			if (!o.dead) begin
				o.scl = add_sat(r.scl, r.p1);
				o.spn = add_sat(r.spn, r.p2);
				o.opa = add_sat(r.opa, r.p3);
				o.vx  = add_sat(r.vx, r.p4);
				o.vy  = add_sat(r.vy, r.p5);
			end
			o.div_ok = !o.dead && (r.lim > 0) && (o.life > 0);
			o.rem    = o.life;
			o.quo    = '0;
		end else if (k == 3) begin
			o = div2(r);
			o.p0 = mulq(r.spn, r.dt);
			o.p1 = mulq(r.vx, r.dt);
			o.p2 = mulq(r.vy, r.dt);
		end else if (k == 4) begin
			o = div2(r);
			if (!r.dead) begin
				o.rot = add_sat(r.rot, r.p0);
				o.px  = add_sat(r.px, r.p1);
				o.py  = add_sat(r.py, r.p2);
			end
		end else if (k < NUM_STAGES) begin
			o = div2(r);
		end else begin
			if (r.div_ok)
				f = {1'b0, r.quo};
			else if (r.lim < 0)
				f = ONE_Q16;
			if (f >= HALF_ONE) begin
				t  = 17'((f - HALF_ONE) << 1);
				ca = color_stops_q[47:24];
				cb = color_end_q;
			end else begin
				t  = 17'(f << 1);
				ca = color_stops_q[23:0];
				cb = color_stops_q[47:24];
			end
			o.tint = r.dead ? 24'd0 : {mix(ca[23:16], cb[23:16], t),
				mix(ca[15:8], cb[15:8], t), mix(ca[7:0], cb[7:0], t)};
			if (r.scl < 0)
				o.scl = '0;
			if (r.opa < 0)
				o.opa = '0;
			else if (r.opa > 32'sd65536)
				o.opa = 32'sd65536;
		end
		return o;
	endfunction

	rec_t                  st [1:NUM_STAGES];
	logic [NUM_STAGES:1]   vld;
	logic [NUM_STAGES-1:0] vin;
	logic [NUM_STAGES+1:1] rdy;
	rec_t                  in_rec;

	// Valid bit entering each stage: the input request for the first one.
	assign vin                 = {vld[NUM_STAGES-1:1], s_tvalid};
	assign in_rec              = unpack_in(s_tdata);
	assign rdy[NUM_STAGES+1]   = m_tready;
	assign s_tready            = rdy[1];

	for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_stage
		assign rdy[k] = !vld[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld[k] <= 1'b0;
			else if (rdy[k])
				vld[k] <= vin[k-1];
		end

		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (rdy[k] && vin[k-1])
					st[k] <= stage_fn(k, in_rec);
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (rdy[k] && vin[k-1])
					st[k] <= stage_fn(k, st[k-1]);
			end
		end
	end

	assign m_tvalid = vld[NUM_STAGES];
	assign m_tuser  = st[NUM_STAGES].dead;
	assign m_tdata  = {st[NUM_STAGES].tint, st[NUM_STAGES].life,
		st[NUM_STAGES].opa[16:0], st[NUM_STAGES].scl[30:0],
		st[NUM_STAGES].spn, st[NUM_STAGES].rot, st[NUM_STAGES].vy,
		st[NUM_STAGES].vx, st[NUM_STAGES].py, st[NUM_STAGES].px};

endmodule
`default_nettype wire

// ----- hw/rtl/psu_checker.sv -----
`default_nettype none
module psu_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [psu_pkg::OUT_W-1:0]  m_tdata,
	input wire logic                       m_tuser
);
	import psu_pkg::*;

	// A dead particle never carries a color.
	a_dead_no_tint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[295:272] == 24'd0)
		else $error("dead particle with nonzero tint");

	// Opacity is clamped to one.
	a_opacity_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[239:223] <= ONE_Q16)
		else $error("opacity above one");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed under stall");

	// Nothing comes out the cycle after reset is released.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind particle_state_update psu_checker u_psu_checker (.*);
`default_nettype wire
